// File: src/fcc_pkg.sv
// Shared types, constants and codes for the checksum checker.
// Depends on nothing; every other file but fcc_if.sv imports it.
package fcc_pkg;

	localparam logic [7:0]  SOH_BYTE   = 8'h01;
	localparam logic [7:0]  EQ_BYTE    = 8'h3D;
	localparam logic [7:0]  ZERO_CHAR  = 8'h30;
	localparam logic [7:0]  NINE_CHAR  = 8'h39;
	localparam logic [23:0] TAG_PREFIX = 24'h013130;
	localparam logic [9:0]  VALUE_MAX  = 10'd1023;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		ST_MATCH        = 3'd0,
		ST_MISMATCH     = 3'd1,
		ST_NO_TAG       = 3'd2,
		ST_UNTERMINATED = 3'd3,
		ST_NO_DIGITS    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_NONE    = 2'd0,
		PH_COLLECT = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       is_soh;
		logic       is_digit;
		logic [3:0] digit;
		logic       tag_hit;
	} cls_beat_t;

endpackage

// File: src/fcc_if.sv
// Valid/ready channel interfaces for message bytes and check results.
// Depends on nothing.
interface fcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fcc_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] check_status;
	logic [7:0] expected_sum;
	logic [9:0] received_sum;
	modport source (output valid, output check_status, output expected_sum,
		output received_sum, input ready);
	modport sink   (input valid, input check_status, input expected_sum,
		input received_sum, output ready);
endinterface

// File: src/fcc_front.sv
// Front part: accepts message bytes, classifies them and spots the checksum tag.
// Depends on fcc_pkg.
module fcc_front
	import fcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       q_push,
	output cls_beat_t  q_beat
);

	logic [23:0] history_q;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept;

	always_comb begin
		q_beat.data_byte = data_byte;
		q_beat.last_byte = last_byte;
		q_beat.is_soh    = (data_byte == SOH_BYTE);
		q_beat.is_digit  = (data_byte >= ZERO_CHAR) && (data_byte <= NINE_CHAR);
		q_beat.digit     = 4'(data_byte - ZERO_CHAR);
		q_beat.tag_hit   = (data_byte == EQ_BYTE) && (history_q == TAG_PREFIX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				history_q <= '0;
			end else begin
				history_q <= {history_q[15:0], data_byte};
			end
		end
	end

endmodule

// File: src/fcc_queue.sv
// Short first-in first-out queue of classified beats between front and back.
// Depends on fcc_pkg.
module fcc_queue
	import fcc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_beat_t push_beat,
	input  logic      pop,
	output cls_beat_t pop_beat,
	output logic      full,
	output logic      empty
);

	cls_beat_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_beat = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/fcc_back.sv
// Back part: keeps the sums, parses the checksum value and registers the result.
// Depends on fcc_pkg.
module fcc_back
	import fcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cls_beat_t  q_beat,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] check_status,
	output logic [7:0] expected_sum,
	output logic [9:0] received_sum
);

	logic [7:0] run_q,      run_n;
	logic [7:0] soh_sum_q,  soh_sum_n;
	logic       tag_q,      tag_n;
	logic [7:0] cap_q,      cap_n;
	phase_t     phase_q,    phase_n;
	logic [9:0] accum_q,    accum_n;
	logic       seen_q,     seen_n;
	logic       stopped_q,  stopped_n;
	logic [13:0] step_val;
	status_t    status_n;
	logic [7:0] exp_n;
	logic [9:0] rcv_n;
	logic       valid_q;
	status_t    status_q;
	logic [7:0] exp_q;
	logic [9:0] rcv_q;

	assign q_pop = !q_empty && (!valid_q || out_ready);

	always_comb begin
		step_val  = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} + {10'd0, q_beat.digit};
		run_n     = run_q + q_beat.data_byte;
		soh_sum_n = q_beat.is_soh ? run_n : soh_sum_q;
		tag_n     = tag_q;
		cap_n     = cap_q;
		phase_n   = phase_q;
		accum_n   = accum_q;
		seen_n    = seen_q;
		stopped_n = stopped_q;
		if (phase_q == PH_COLLECT) begin
			if (q_beat.is_soh) begin
				phase_n = PH_DONE;
			end else if (!stopped_q) begin
				if (q_beat.is_digit) begin
					accum_n = (step_val > 14'(VALUE_MAX)) ? VALUE_MAX : step_val[9:0];
					seen_n  = 1'b1;
				end else begin
					stopped_n = 1'b1;
				end
			end
		end
		if (q_beat.tag_hit) begin
			tag_n     = 1'b1;
			cap_n     = soh_sum_q;
			phase_n   = PH_COLLECT;
			accum_n   = '0;
			seen_n    = 1'b0;
			stopped_n = 1'b0;
		end
		exp_n = cap_n;
		rcv_n = '0;
		if (!tag_n) begin
			status_n = ST_NO_TAG;
			exp_n    = '0;
		end else if (phase_n != PH_DONE) begin
			status_n = ST_UNTERMINATED;
		end else if (!seen_n) begin
			status_n = ST_NO_DIGITS;
		end else begin
			rcv_n    = accum_n;
			status_n = (accum_n == {2'b00, cap_n}) ? ST_MATCH : ST_MISMATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= '0;
			soh_sum_q <= '0;
			tag_q     <= 1'b0;
			cap_q     <= '0;
			phase_q   <= PH_NONE;
			accum_q   <= '0;
			seen_q    <= 1'b0;
			stopped_q <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_beat.last_byte) begin
					run_q     <= '0;
					soh_sum_q <= '0;
					tag_q     <= 1'b0;
					cap_q     <= '0;
					phase_q   <= PH_NONE;
					accum_q   <= '0;
					seen_q    <= 1'b0;
					stopped_q <= 1'b0;
				end else begin
					run_q     <= run_n;
					soh_sum_q <= soh_sum_n;
					tag_q     <= tag_n;
					cap_q     <= cap_n;
					phase_q   <= phase_n;
					accum_q   <= accum_n;
					seen_q    <= seen_n;
					stopped_q <= stopped_n;
				end
			end
			if (q_pop && q_beat.last_byte) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_beat.last_byte) begin
			status_q <= status_n;
			exp_q    <= exp_n;
			rcv_q    <= rcv_n;
		end
	end

	assign out_valid    = valid_q;
	assign check_status = status_q;
	assign expected_sum = exp_q;
	assign received_sum = rcv_q;

endmodule

// File: src/fix_checksum_checker_unit.sv
// Checksum checker top level: front classifier, four-beat queue, back checker.
// Throughput: one byte beat per cycle, sustained while results are taken.
// The final byte is written into the queue and later popped by the back part, which
// registers the result beat; beats waiting ahead of it are popped first, and a stalled
// result beat holds the queue. Reset: arst_n clears sums, parser state, queue
// pointers and the result valid flag.
module fix_checksum_checker_unit
	import fcc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	fcc_byte_if.sink            msg,
	fcc_result_if.source        result
);

	logic      q_full;
	logic      q_empty;
	logic      q_push;
	logic      q_pop;
	cls_beat_t push_beat;
	cls_beat_t pop_beat;

	fcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (msg.valid),
		.in_ready  (msg.ready),
		.data_byte (msg.data_byte),
		.last_byte (msg.last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_beat    (push_beat)
	);

	fcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_beat (push_beat),
		.pop       (q_pop),
		.pop_beat  (pop_beat),
		.full      (q_full),
		.empty     (q_empty)
	);

	fcc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_beat       (pop_beat),
		.q_pop        (q_pop),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.check_status (result.check_status),
		.expected_sum (result.expected_sum),
		.received_sum (result.received_sum)
	);

endmodule

// File: src/fcc_checker.sv
// Port-level assertions on the result channel of the checksum checker.
// Depends on fcc_pkg; bound to fix_checksum_checker_unit below.
module fcc_checker
	import fcc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] check_status,
	input logic [7:0] expected_sum,
	input logic [9:0] received_sum
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(check_status) && $stable(expected_sum)
			&& $stable(received_sum))
		else $error("result payload changed while stalled");

	a_no_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && check_status == ST_NO_TAG |-> expected_sum == '0 && received_sum == '0)
		else $error("sums not cleared when no checksum tag");

	a_no_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (check_status == ST_UNTERMINATED || check_status == ST_NO_DIGITS)
			|-> received_sum == '0)
		else $error("received sum not cleared without a value");

	a_match_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && check_status == ST_MATCH |-> received_sum == {2'b00, expected_sum})
		else $error("match reported with unequal sums");

endmodule

bind fix_checksum_checker_unit fcc_checker u_fcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.check_status (result.check_status),
	.expected_sum (result.expected_sum),
	.received_sum (result.received_sum)
);

// File: tb/tb_fix_checksum_checker_unit.sv
// Self-checking testbench for the FIX checksum checker: directed messages first, then random
// framed messages with random gaps on both channels, checked against an in-bench verdict model.
// Depends on fcc_pkg, the channel interfaces in fcc_if.sv and fix_checksum_checker_unit.
module tb_fix_checksum_checker_unit;
	import fcc_pkg::*;

	typedef logic [7:0] msg_bytes_t[$];

	typedef struct {
		status_t    status;
		logic [7:0] expected_sum;
		logic [9:0] received_sum;
	} verdict_t;

	class fix_checksum_tracker;
		logic [7:0]  total;
		logic [7:0]  soh_sum;
		logic [23:0] history;
		bit          tag_seen;
		logic [7:0]  tag_sum;
		phase_t      phase;
		logic [9:0]  value;
		bit          got_digit;
		bit          stopped;
		verdict_t    verdicts_due[$];

		function new();
			clear();
		endfunction

		function void clear();
			total     = '0;
			soh_sum   = '0;
			history   = '0;
			tag_seen  = 1'b0;
			tag_sum   = '0;
			phase     = PH_NONE;
			value     = '0;
			got_digit = 1'b0;
			stopped   = 1'b0;
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction

		function void absorb_byte(logic [7:0] b, logic l);
			int       grown;
			verdict_t v;
			if (phase == PH_COLLECT) begin
				if (b == SOH_BYTE) begin
					phase = PH_DONE;
				end else if (!stopped) begin
					if (b >= ZERO_CHAR && b <= NINE_CHAR) begin
						grown = int'(value) * 10 + int'(b - ZERO_CHAR);
						value = (grown > int'(VALUE_MAX)) ? VALUE_MAX : grown[9:0];
						got_digit = 1'b1;
					end else begin
						stopped = 1'b1;
					end
				end
			end
			if (b == EQ_BYTE && history == TAG_PREFIX) begin
				tag_seen  = 1'b1;
				tag_sum   = soh_sum;
				phase     = PH_COLLECT;
				value     = '0;
				got_digit = 1'b0;
				stopped   = 1'b0;
			end
			total = total + b;
			if (b == SOH_BYTE) begin
				soh_sum = total;
			end
			history = {history[15:0], b};
			if (!l) begin
				return;
			end
			v.expected_sum = tag_sum;
			v.received_sum = '0;
			if (!tag_seen) begin
				v.status = ST_NO_TAG;
				v.expected_sum = '0;
			end else if (phase != PH_DONE) begin
				v.status = ST_UNTERMINATED;
			end else if (!got_digit) begin
				v.status = ST_NO_DIGITS;
			end else begin
				v.received_sum = value;
				v.status = (value == {2'b00, tag_sum}) ? ST_MATCH : ST_MISMATCH;
			end
			verdicts_due.push_back(v);
			clear();
		endfunction

		function string match_verdict(logic [2:0] s, logic [7:0] e, logic [9:0] r);
			verdict_t v;
			string    diff;
			if (verdicts_due.size() == 0) begin
				return $sformatf("result with nothing expected: status %0d sums %0d/%0d",
					s, e, r);
			end
			v = verdicts_due.pop_front();
			diff = "";
			if (s !== v.status) begin
				diff = {diff, $sformatf(" status %0d want %0d", s, v.status)};
			end
			if (e !== v.expected_sum) begin
				diff = {diff, $sformatf(" expected_sum %0d want %0d", e, v.expected_sum)};
			end
			if (r !== v.received_sum) begin
				diff = {diff, $sformatf(" received_sum %0d want %0d", r, v.received_sum)};
			end
			return diff;
		endfunction
	endclass

	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count = 0;
	int   stall_cycles = 0;
	fix_checksum_tracker tracker = new();

	fcc_byte_if   msg_ch();
	fcc_result_if res_ch();

	fix_checksum_checker_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.result (res_ch)
	);

	always #10 clk = ~clk;

	task automatic report(input string what);
		fail_count++;
		$display("MISMATCH at %0t:%s", $realtime, what);
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == SOH_BYTE || (b >= ZERO_CHAR && b <= NINE_CHAR));
		return b;
	endfunction

	function automatic void append_text(ref msg_bytes_t m, input string s);
		for (int i = 0; i < s.len(); i++) m.push_back(s[i]);
	endfunction

	function automatic void append_field(ref msg_bytes_t m);
		append_text(m, $sformatf("%0d=", $urandom_range(1, 999)));
		repeat ($urandom_range(0, 6)) begin
			if ($urandom_range(0, 4) == 0) m.push_back(8'($urandom_range(0, 255)));
			else m.push_back(8'($urandom_range(8'h20, 8'h7E)));
		end
		m.push_back(SOH_BYTE);
	endfunction

	function automatic void build_message(ref msg_bytes_t m);
		int         kind;
		bit         closed;
		logic [7:0] sum;
		m.delete();
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 20)) m.push_back(8'($urandom_range(0, 255)));
			return;
		end
		append_text(m, "8=FIX.4.4");
		m.push_back(SOH_BYTE);
		repeat ($urandom_range(0, 3)) append_field(m);
		if (kind < 15) begin
			return;
		end
		if (kind < 20) begin
			append_text(m, $sformatf("10=%03d", $urandom_range(0, 255)));
			m.push_back(SOH_BYTE);
			append_field(m);
		end
		sum = '0;
		foreach (m[i]) sum = sum + m[i];
		append_text(m, "10=");
		closed = 1'b1;
		if (kind < 55) begin
			append_text(m, $urandom_range(0, 1) ? $sformatf("%03d", sum) : $sformatf("%0d", sum));
		end else if (kind < 65) begin
			append_text(m, $sformatf("%03d", $urandom_range(0, 255)));
		end else if (kind < 72) begin
			append_text(m, $sformatf("%0d", $urandom_range(256, 99999)));
		end else if (kind < 79) begin
			append_text(m, $sformatf("%0d", sum));
			repeat ($urandom_range(1, 3)) m.push_back(non_digit());
			if ($urandom_range(0, 1)) append_text(m, $sformatf("%0d", $urandom_range(0, 999)));
		end else if (kind < 86) begin
			case ($urandom_range(0, 4))
				0: append_text(m, " ");
				1: append_text(m, "+");
				2: append_text(m, "-");
				3: m.push_back(non_digit());
				default: ;
			endcase
			if ($urandom_range(0, 1)) append_text(m, $sformatf("%0d", sum));
		end else if (kind < 93) begin
			closed = 1'b0;
			if ($urandom_range(0, 3) != 0) append_text(m, $sformatf("%0d", sum));
			repeat ($urandom_range(0, 3)) m.push_back(non_digit());
		end else begin
			append_text(m, $sformatf("%0d", $urandom_range(0, 1023)));
		end
		if (closed) begin
			m.push_back(SOH_BYTE);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6)) m.push_back(8'($urandom_range(0, 255)));
			end
		end
		if (m.size() == 0) m.push_back(SOH_BYTE);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l, input bit calm);
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			msg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_ch.valid     <= 1'b1;
		msg_ch.data_byte <= b;
		msg_ch.last_byte <= l;
		do @(posedge clk); while (!msg_ch.ready);
	endtask

	task automatic send_message(input msg_bytes_t m, inout int sent);
		bit calm;
		calm = ($urandom_range(0, 9) < 2);
		foreach (m[i]) begin
			send_byte(m[i], i == m.size() - 1, calm);
			sent++;
		end
	endtask

	task automatic wait_drained();
		msg_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	always @(posedge clk) begin : channel_monitor
		string diff;
		if (msg_ch.valid && msg_ch.ready) begin
			tracker.absorb_byte(msg_ch.data_byte, msg_ch.last_byte);
		end
		if (res_ch.valid && res_ch.ready) begin
			diff = tracker.match_verdict(res_ch.check_status, res_ch.expected_sum,
				res_ch.received_sum);
			if (diff != "") begin
				report(diff);
			end
		end
		if ((msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_fix_checksum_checker_unit failed");
			$finish;
		end
	end

	initial begin : result_pacing
		int gap;
		bit calm;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			calm = ($urandom_range(0, 9) < 2);
			gap = calm ? 0 : idle_len();
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat (calm ? $urandom_range(20, 60) : $urandom_range(1, 4)) @(posedge clk);
		end
	end

	initial begin : byte_stimulus
		msg_bytes_t m;
		int         sent;
		int         messages;
		int         directed;
		arst_n           = 1'b0;
		msg_ch.valid     = 1'b0;
		msg_ch.data_byte = '0;
		msg_ch.last_byte = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short directed messages: no tag, match, mismatch with trailing text,
		// empty value and a value cut off by the end of the message.
		directed = 0;
		m = '{8'hFF};
		send_message(m, directed);
		m = '{SOH_BYTE};
		append_text(m, "10=1");
		m.push_back(SOH_BYTE);
		send_message(m, directed);
		m = '{SOH_BYTE};
		append_text(m, "10=2a");
		m.push_back(SOH_BYTE);
		send_message(m, directed);
		m = '{SOH_BYTE};
		append_text(m, "10=");
		m.push_back(SOH_BYTE);
		send_message(m, directed);
		m = '{SOH_BYTE};
		append_text(m, "10=1");
		send_message(m, directed);
		wait_drained();

		sent = 0;
		messages = 0;
		while (sent < 900) begin
			build_message(m);
			send_message(m, sent);
			messages++;
			if (messages == 10 || $urandom_range(0, 19) == 0) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (tracker.pending() != 0) begin
			report($sformatf(" %0d results never arrived", tracker.pending()));
		end
		if (fail_count == 0) begin
			$display("tb_fix_checksum_checker_unit passed");
		end else begin
			$display("tb_fix_checksum_checker_unit failed");
		end
		$finish;
	end
endmodule
